FILE: rtl/core/rtlock_pkg.sv
// Shared types and codes for the recursive ticket lock.
// Used by the channel interfaces, the controller, the datapath and the checker.
`timescale 1ns / 1ps

package rtlock_pkg;

  localparam int OPCODE_W     = 3;
  localparam int CPU_ID_W     = 3;
  localparam int COUNT_W      = 8;
  localparam int REP_DEPTH_W  = 16;
  localparam int TICKET_OUT_W = 32;
  localparam int STATUS_W     = 2;

  typedef logic [OPCODE_W-1:0]     opcode_t;
  typedef logic [CPU_ID_W-1:0]     cpu_id_t;
  typedef logic [COUNT_W-1:0]      count_t;
  typedef logic [REP_DEPTH_W-1:0]  rep_depth_t;
  typedef logic [TICKET_OUT_W-1:0] ticket_out_t;
  typedef logic [STATUS_W-1:0]     status_t;

  localparam opcode_t OP_ACQUIRE         = 3'd0;
  localparam opcode_t OP_RELEASE         = 3'd1;
  localparam opcode_t OP_RELEASE_ALL     = 3'd2;
  localparam opcode_t OP_RELEASE_BUT_ONE = 3'd3;
  localparam opcode_t OP_QUERY           = 3'd4;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOT_HELD = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch the request and start the entry read
    logic exec;     // update the entry and counters, load the result register
  } dp_cmd_t;

endpackage

FILE: rtl/core/rtlock_if.sv
// Valid/ready channel interfaces for lock requests and lock results.
// Depends on rtlock_pkg for the field types.
`timescale 1ns / 1ps

interface rtlock_req_if;
  import rtlock_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  cpu_id_t cpu_id;
  count_t  acquire_count;

  modport source (output valid, output opcode, output cpu_id, output acquire_count,
                  input ready);
  modport sink   (input valid, input opcode, input cpu_id, input acquire_count,
                  output ready);
endinterface

interface rtlock_rsp_if;
  import rtlock_pkg::*;

  logic        valid;
  logic        ready;
  logic        owns_lock;
  logic        waiting;
  rep_depth_t  reported_depth;
  ticket_out_t my_ticket;
  status_t     status;

  modport source (output valid, output owns_lock, output waiting, output reported_depth,
                  output my_ticket, output status, input ready);
  modport sink   (input valid, input owns_lock, input waiting, input reported_depth,
                  input my_ticket, input status, output ready);
endinterface

FILE: rtl/core/recursive_ticket_lock.sv
// Recursive ticket lock, top level: controller plus datapath.
// Depends on rtlock_pkg, rtlock_if, rtlock_ctrl and rtlock_dp.
//
// Usage:
//   in_chan carries one lock request item: opcode, cpu_id, acquire_count.
//   out_chan returns exactly one result item per request: owns_lock, waiting,
//   reported_depth, my_ticket, status. Both channels are valid/ready.
//   The request and the per-CPU entry are registered at the accept; the result
//   register loads when the update runs with the result slot free.
//   A new request is accepted only once the previous one has done its update:
//   the registered read of the per-CPU entry is followed by its read-modify-write.
//   The result sits in an output register, so the next request is accepted
//   while a result still waits; if out_chan stays stalled the update of that
//   next request waits and in_chan ready stays low until the slot frees.
//   Reset (rst_n low) is synchronous: all depths and tickets read as zero,
//   the issue counter is zero and now-serving is one.
//   Waiting CPUs poll with the query opcode until owns_lock is set.
`timescale 1ns / 1ps

module recursive_ticket_lock #(
  parameter int NUM_CPUS    = 8,
  parameter int TICKET_BITS = 32,
  parameter int DEPTH_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rtlock_req_if.sink  in_chan,
  rtlock_rsp_if.source out_chan
);
  import rtlock_pkg::*;

  dp_cmd_t cmd;

  rtlock_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  rtlock_dp #(
    .NUM_CPUS    (NUM_CPUS),
    .TICKET_BITS (TICKET_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_opcode          (in_chan.opcode),
    .in_cpu_id          (in_chan.cpu_id),
    .in_acquire_count   (in_chan.acquire_count),
    .out_owns_lock      (out_chan.owns_lock),
    .out_waiting        (out_chan.waiting),
    .out_reported_depth (out_chan.reported_depth),
    .out_my_ticket      (out_chan.my_ticket),
    .out_status         (out_chan.status)
  );

endmodule

FILE: rtl/core/rtlock_ctrl.sv
// Controller for the recursive ticket lock: sequences accept, entry update and
// result hand-off. Depends on rtlock_pkg for the command struct.
`timescale 1ns / 1ps

module rtlock_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rtlock_pkg::dp_cmd_t cmd
);
  import rtlock_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // result register can take a new item if empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && (state_r == S_IDLE);
  assign cmd.exec    = (state_r == S_EXEC) && slot_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/rtlock_dp.sv
// Datapath for the recursive ticket lock: per-CPU depth and ticket store,
// issue and now-serving counters, result register. Depends on rtlock_pkg.
`timescale 1ns / 1ps

module rtlock_dp #(
  parameter int NUM_CPUS    = 8,
  parameter int TICKET_BITS = 32,
  parameter int DEPTH_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rtlock_pkg::dp_cmd_t      cmd,
  input  rtlock_pkg::opcode_t      in_opcode,
  input  rtlock_pkg::cpu_id_t      in_cpu_id,
  input  rtlock_pkg::count_t       in_acquire_count,
  output logic                     out_owns_lock,
  output logic                     out_waiting,
  output rtlock_pkg::rep_depth_t   out_reported_depth,
  output rtlock_pkg::ticket_out_t  out_my_ticket,
  output rtlock_pkg::status_t      out_status
);
  import rtlock_pkg::*;

  localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SUM_W = ((DEPTH_BITS > COUNT_W) ? DEPTH_BITS : COUNT_W) + 1;

  typedef logic [DEPTH_BITS-1:0]  depth_t;
  typedef logic [TICKET_BITS-1:0] ticket_t;

  // per-CPU store; entries without a valid bit read as zero
  depth_t              depth_mem_r  [NUM_CPUS];
  ticket_t             ticket_mem_r [NUM_CPUS];
  logic [NUM_CPUS-1:0] entry_vld_r;

  ticket_t issued_r, issued_nxt;
  ticket_t serving_r, serving_nxt;

  // captured request
  opcode_t          op_r;
  count_t           cnt_r;
  logic             cpu_ok_r;
  logic [IDX_W-1:0] idx_r;
  depth_t           rd_depth_r;
  ticket_t          rd_ticket_r;
  logic             rd_vld_r;

  // result register
  logic        owns_r, waiting_r;
  rep_depth_t  rep_r;
  ticket_out_t ticket_out_r;
  status_t     status_r;

  logic [IDX_W-1:0] in_idx;
  depth_t           cur_depth, new_depth, report;
  ticket_t          cur_ticket, new_ticket;
  logic [SUM_W-1:0] sum;
  logic             ovf, depth_zero, served;
  status_t          status_nxt;

  assign in_idx = IDX_W'(in_cpu_id);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_opcode;
      cnt_r       <= in_acquire_count;
      cpu_ok_r    <= (32'(in_cpu_id) < NUM_CPUS);
      idx_r       <= in_idx;
      rd_depth_r  <= depth_mem_r[in_idx];
      rd_ticket_r <= ticket_mem_r[in_idx];
      rd_vld_r    <= entry_vld_r[in_idx];
    end
  end

  assign cur_depth  = rd_vld_r ? rd_depth_r  : '0;
  assign cur_ticket = rd_vld_r ? rd_ticket_r : '0;
  assign sum        = SUM_W'(cur_depth) + SUM_W'(cnt_r);
  assign ovf        = (sum >> DEPTH_BITS) != '0;
  assign depth_zero = (cur_depth == '0);

  always_comb begin
    new_depth   = cur_depth;
    new_ticket  = cur_ticket;
    issued_nxt  = issued_r;
    serving_nxt = serving_r;
    status_nxt  = ST_OK;
    report      = cur_depth;
    unique case (op_r)
      OP_ACQUIRE: begin
        if (cnt_r != '0) begin
          if (ovf) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            if (depth_zero) begin
              issued_nxt = issued_r + 1'b1;
              new_ticket = issued_nxt;
            end
            new_depth = sum[DEPTH_BITS-1:0];
          end
        end
        report = new_depth;
      end
      OP_RELEASE: begin
        if (depth_zero) begin
          status_nxt = ST_NOT_HELD;
          report     = '0;
        end else begin
          new_depth = cur_depth - 1'b1;
          if (new_depth == '0) begin
            serving_nxt = serving_r + 1'b1;
          end
          report = new_depth;
        end
      end
      OP_RELEASE_ALL: begin
        if (depth_zero) begin
          status_nxt = ST_NOT_HELD;
          report     = '0;
        end else begin
          report      = cur_depth;
          new_depth   = '0;
          serving_nxt = serving_r + 1'b1;
        end
      end
      OP_RELEASE_BUT_ONE: begin
        if (depth_zero) begin
          status_nxt = ST_NOT_HELD;
          report     = '0;
        end else begin
          report    = cur_depth - 1'b1;
          new_depth = DEPTH_BITS'(1);
        end
      end
      default: begin
        // query and unused codes only report
        report = cur_depth;
      end
    endcase
  end

  assign served = (new_ticket == serving_nxt);

  // store write-back
  always_ff @(posedge clk) begin
    if (cmd.exec && cpu_ok_r) begin
      depth_mem_r[idx_r]  <= new_depth;
      ticket_mem_r[idx_r] <= new_ticket;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      issued_r    <= '0;
      serving_r   <= TICKET_BITS'(1);
    end else if (cmd.exec && cpu_ok_r) begin
      entry_vld_r[idx_r] <= 1'b1;
      issued_r           <= issued_nxt;
      serving_r          <= serving_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (cpu_ok_r) begin
        owns_r       <= (new_depth != '0) && served;
        waiting_r    <= (new_depth != '0) && !served;
        rep_r        <= REP_DEPTH_W'(report);
        ticket_out_r <= TICKET_OUT_W'(new_ticket);
        status_r     <= status_nxt;
      end else begin
        owns_r       <= 1'b0;
        waiting_r    <= 1'b0;
        rep_r        <= '0;
        ticket_out_r <= '0;
        status_r     <= ST_OK;
      end
    end
  end

  assign out_owns_lock      = owns_r;
  assign out_waiting        = waiting_r;
  assign out_reported_depth = rep_r;
  assign out_my_ticket      = ticket_out_r;
  assign out_status         = status_r;

endmodule

FILE: rtl/core/rtlock_checker.sv
// Port-level checks for the recursive ticket lock, bound to the top level.
// Depends on rtlock_pkg for the status codes.
`timescale 1ns / 1ps

module rtlock_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_owns_lock,
  input logic                   out_waiting,
  input rtlock_pkg::rep_depth_t out_reported_depth,
  input rtlock_pkg::status_t    out_status
);
  import rtlock_pkg::*;

  // one request in work at a time: an accept closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is still in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_own_xor_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_owns_lock && out_waiting) && (out_status != 2'd3))
    else $error("inconsistent ownership or status code");

  // a refused release leaves the CPU with nothing held
  a_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_HELD) |->
      !out_owns_lock && !out_waiting && (out_reported_depth == '0))
    else $error("release while not held reports a held lock");

endmodule

bind recursive_ticket_lock rtlock_checker u_rtlock_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_owns_lock      (out_chan.owns_lock),
  .out_waiting        (out_chan.waiting),
  .out_reported_depth (out_chan.reported_depth),
  .out_status         (out_chan.status)
);
